// File: sv/ctam_pkg.sv
// ----------------------------------------------------------------------------
// ctam_pkg
// Shared types and constants of the causal tree attention mask core.
// ----------------------------------------------------------------------------
package ctam_pkg;

	// Default store dimensions.
	localparam int DEF_MAX_ROWS = 64;
	localparam int DEF_MAX_COLS = 64;

	// Configuration port widths.
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 7;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT     = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH    = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CONTEXT_ROWS  = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COLUMN_OFFSET = 8'd3;

	// Negative infinity in IEEE single precision.
	localparam logic [31:0] NEG_INF_BITS = 32'hFF80_0000;

	// One score request.
	typedef struct packed {
		logic [31:0] score_bits;
		logic [5:0]  ancestor_row;
	} in_item_t;

	// One result.
	typedef struct packed {
		logic [31:0] value_bits;
		logic        masked;
		logic        row_end;
	} out_item_t;

endpackage

// File: sv/causal_tree_attention_mask_core.sv
// ----------------------------------------------------------------------------
// causal_tree_attention_mask_core
// Streams attention scores and replaces masked ones by negative infinity.
// ----------------------------------------------------------------------------
// Usage:
// Scores of one head enter on the in channel in row-major order, one request
// per score, each with the tree parent row of its query row. Every request
// gives exactly one result on the out channel: the score or negative
// infinity, a masked flag and a row end flag. Configuration writes on the cfg
// channel (always ready) set the row count, row length, context rows and
// column offset, and each write restarts the head at row zero, column zero.
// A result passes the second stage and the output register before it is
// offered. The block takes one request every cycle unless the receiver
// stalls; the rate is set by the one read port of the one-bit mask store
// in the first stage and its write-back in the second, with the bit
// written back forwarded to a read of the same entry in that cycle.
// When the receiver stalls, the output register holds its result and the
// second stage holds its request, so at most two requests are in flight
// before in_ready drops. Reset clears the counters, the valid flags, the
// context rows and column offset and sets row count and length to one; the
// mask store is not cleared, as each entry is written in the head before a read.
// ----------------------------------------------------------------------------
module causal_tree_attention_mask_core #(
	parameter int MAX_ROWS = ctam_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = ctam_pkg::DEF_MAX_COLS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  ctam_pkg::in_item_t             in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output ctam_pkg::out_item_t            out_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ctam_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ctam_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int ROW_W  = $clog2(MAX_ROWS);
	localparam int COL_W  = $clog2(MAX_COLS);
	localparam int ROWS_W = $clog2(MAX_ROWS + 1);
	localparam int COLS_W = $clog2(MAX_COLS + 1);
	localparam int DEPTH  = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int MAXW   = (ROW_W > COL_W) ? ROW_W : COL_W;
	localparam int CW     = ((MAXW > ctam_pkg::CFG_DATA_W) ? MAXW : ctam_pkg::CFG_DATA_W) + 2;

	// Configuration registers.
	logic [ctam_pkg::CFG_DATA_W-1:0] row_count_q;
	logic [ctam_pkg::CFG_DATA_W-1:0] row_length_q;
	logic [ctam_pkg::CFG_DATA_W-1:0] context_rows_q;
	logic [ctam_pkg::CFG_DATA_W-1:0] column_offset_q;

	// Position counters.
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;

	// Handshake and pipeline control.
	logic in_acc;
	logic cfg_acc;
	logic s1_adv;
	logic valid_s1;

	// First stage results.
	logic [ROWS_W-1:0] rows_eff;
	logic [COLS_W-1:0] cols_eff;
	logic              last;
	logic              is_context;
	logic              causal_mask;
	logic              use_map;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] wr_addr;
	logic signed [CW-1:0] col_s;
	logic signed [CW-1:0] row_s;
	logic signed [CW-1:0] off_s;

	// Second stage registers.
	logic [31:0]       score_s1;
	logic              fix_mask_s1;
	logic              use_map_s1;
	logic              fwd_s1;
	logic              fwd_bit_s1;
	logic              rd_bit_s1;
	logic [ADDR_W-1:0] wr_addr_s1;
	logic              row_end_s1;
	logic              mask_s1;
	logic [31:0]       value_s1;
	logic              neg_s1;

	// Output register.
	logic               out_valid_q;
	ctam_pkg::out_item_t out_q;

	// One-bit store: was the output negative infinity at this row and column.
	logic mem [DEPTH];

	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid;
	assign s1_adv    = !out_valid_q || out_ready;
	assign in_ready  = !valid_s1 || s1_adv;
	assign in_acc    = in_valid && in_ready;

	// Effective row count and row length after clamping.
	always_comb begin
		if (row_count_q == '0) begin
			rows_eff = ROWS_W'(1);
		end else if (32'(row_count_q) > 32'(MAX_ROWS)) begin
			rows_eff = ROWS_W'(MAX_ROWS);
		end else begin
			rows_eff = ROWS_W'(row_count_q);
		end
		if (row_length_q == '0) begin
			cols_eff = COLS_W'(1);
		end else if (32'(row_length_q) > 32'(MAX_COLS)) begin
			cols_eff = COLS_W'(MAX_COLS);
		end else begin
			cols_eff = COLS_W'(row_length_q);
		end
	end

	// Mask decision of the first stage and the store addresses.
	always_comb begin
		col_s       = CW'(col_q);
		row_s       = CW'(row_q);
		off_s       = {{(CW - ctam_pkg::CFG_DATA_W){column_offset_q[ctam_pkg::CFG_DATA_W-1]}},
			column_offset_q};
		last        = (COLS_W'(col_q) + COLS_W'(1)) == cols_eff;
		is_context  = 32'(row_q) < 32'(context_rows_q);
		causal_mask = (rows_eff > ROWS_W'(1)) && is_context && (col_s > (row_s + off_s));
		use_map     = (rows_eff > ROWS_W'(1)) && !is_context
			&& (32'(col_q) != 32'(row_q))
			&& (32'(in_data.ancestor_row) < 32'(row_q));
		rd_addr     = use_map ? (ADDR_W'(in_data.ancestor_row) * ADDR_W'(MAX_COLS)
			+ ADDR_W'(col_q)) : '0;
		wr_addr     = ADDR_W'(row_q) * ADDR_W'(MAX_COLS) + ADDR_W'(col_q);
	end

	// Configuration writes, each restarting the head.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q     <= ctam_pkg::CFG_DATA_W'(1);
			row_length_q    <= ctam_pkg::CFG_DATA_W'(1);
			context_rows_q  <= '0;
			column_offset_q <= '0;
		end else if (cfg_acc) begin
			unique case (cfg_index)
				ctam_pkg::REG_ROW_COUNT:     row_count_q     <= cfg_data;
				ctam_pkg::REG_ROW_LENGTH:    row_length_q    <= cfg_data;
				ctam_pkg::REG_CONTEXT_ROWS:  context_rows_q  <= cfg_data;
				ctam_pkg::REG_COLUMN_OFFSET: column_offset_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Row and column counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (cfg_acc) begin
			row_q <= '0;
			col_q <= '0;
		end else if (in_acc) begin
			if (last) begin
				col_q <= '0;
				if ((ROWS_W'(row_q) + ROWS_W'(1)) >= rows_eff) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + ROW_W'(1);
				end
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// Store read in the first stage, write-back when the second stage moves on.
	always_ff @(posedge clk) begin
		if (valid_s1 && s1_adv) begin
			mem[wr_addr_s1] <= neg_s1;
		end
		if (in_acc) begin
			rd_bit_s1 <= mem[rd_addr];
		end
	end

	// Second stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_acc;
		end
	end

	// Second stage payload, with forwarding of the bit being written back.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			score_s1    <= in_data.score_bits;
			fix_mask_s1 <= causal_mask;
			use_map_s1  <= use_map;
			fwd_s1      <= valid_s1 && (rd_addr == wr_addr_s1);
			fwd_bit_s1  <= neg_s1;
			wr_addr_s1  <= wr_addr;
			row_end_s1  <= last;
		end
	end

	// Final mask and value of the second stage.
	always_comb begin
		mask_s1  = fix_mask_s1 || (use_map_s1 && (fwd_s1 ? fwd_bit_s1 : rd_bit_s1));
		value_s1 = mask_s1 ? ctam_pkg::NEG_INF_BITS : score_s1;
		neg_s1   = value_s1 == ctam_pkg::NEG_INF_BITS;
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && valid_s1) begin
			out_q.value_bits <= value_s1;
			out_q.masked     <= neg_s1;
			out_q.row_end    <= row_end_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// The row counter always stays inside the configured head.
	a_row_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ROWS_W'(row_q) < rows_eff)
		else $error("row counter beyond row count");

	// The column counter always stays inside the configured row.
	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		COLS_W'(col_q) < cols_eff)
		else $error("column counter beyond row length");

	// A configuration write restarts the head.
	a_cfg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> (row_q == '0) && (col_q == '0))
		else $error("head not restarted after configuration write");

	// The masked flag of a result matches its value.
	a_masked_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.masked == (out_data.value_bits == ctam_pkg::NEG_INF_BITS)))
		else $error("masked flag disagrees with value");

endmodule

// File: tb/sv/tb_causal_tree_attention_mask_core.sv
// ----------------------------------------------------------------------------
// tb_causal_tree_attention_mask_core
// Self-checking bench for the causal tree attention mask core.
// ----------------------------------------------------------------------------
// A queue of score requests is filled phase by phase. Later phases start with
// register writes made while the core is idle. A driver presents the requests
// and a monitor predicts the mask for every accepted request, then compares
// each result field by field. The short directed opening covers pass-through,
// the causal rule on context rows, the diagonal and copied bits on draft rows,
// ancestors that are not earlier rows, clamped counts and writes to unused
// indexes. Random phases follow under three idling regimes.
// ----------------------------------------------------------------------------
module tb_causal_tree_attention_mask_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAP_BITS    = ctam_pkg::DEF_MAX_ROWS * ctam_pkg::DEF_MAX_COLS;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_WAIT  = 8;

	// Register copy, position counters and the per-entry negative infinity map.
	typedef struct {
		logic [6:0]        rows_reg;
		logic [6:0]        len_reg;
		logic [6:0]        ctx_reg;
		logic signed [6:0] off_reg;
		int                row_pos;
		int                col_pos;
		bit [MAP_BITS-1:0] neg_inf_map;
	} mask_state_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	ctam_pkg::in_item_t   in_data = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	ctam_pkg::out_item_t  out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [ctam_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [ctam_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	ctam_pkg::in_item_t  score_feed[$];
	ctam_pkg::out_item_t expected_results[$];
	mask_state_t plan_st;
	mask_state_t live_st;
	bit          in_took = 1'b0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          errors = 0;
	int          cycle_count = 0;

	causal_tree_attention_mask_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Clock with an 8 ns period.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Counts of zero read as one, counts above the store size read as the size.
	function automatic int eff_count(input logic [6:0] v, input int hi);
		int n;
		n = v;
		if (n < 1) return 1;
		if (n > hi) return hi;
		return n;
	endfunction

	function automatic mask_state_t fresh_state();
		mask_state_t s;
		s.rows_reg    = 7'd1;
		s.len_reg     = 7'd1;
		s.ctx_reg     = 7'd0;
		s.off_reg     = 7'sd0;
		s.row_pos     = 0;
		s.col_pos     = 0;
		s.neg_inf_map = '0;
		return s;
	endfunction

	// Any write, to a known index or not, restarts the head.
	function automatic void apply_reg(inout mask_state_t s,
		input logic [ctam_pkg::CFG_IDX_W-1:0] idx,
		input logic [ctam_pkg::CFG_DATA_W-1:0] val);
		case (idx)
			ctam_pkg::REG_ROW_COUNT: begin
				s.rows_reg = val;
			end
			ctam_pkg::REG_ROW_LENGTH: begin
				s.len_reg = val;
			end
			ctam_pkg::REG_CONTEXT_ROWS: begin
				s.ctx_reg = val;
			end
			ctam_pkg::REG_COLUMN_OFFSET: begin
				s.off_reg = val;
			end
			default: begin
			end
		endcase
		s.row_pos = 0;
		s.col_pos = 0;
	endfunction

	// Works out the result of one score request and advances the position.
	function automatic ctam_pkg::out_item_t mask_step(inout mask_state_t s,
		input ctam_pkg::in_item_t req);
		int                  rows;
		int                  cols;
		int                  r;
		int                  c;
		int                  off;
		bit                  hide;
		ctam_pkg::out_item_t res;
		rows = eff_count(s.rows_reg, ctam_pkg::DEF_MAX_ROWS);
		cols = eff_count(s.len_reg, ctam_pkg::DEF_MAX_COLS);
		r    = (s.row_pos >= rows) ? 0 : s.row_pos;
		c    = (s.col_pos >= cols) ? 0 : s.col_pos;
		off  = s.off_reg;
		hide = 1'b0;
		if (rows > 1) begin
			if (r < int'(s.ctx_reg)) begin
				// Context row: causal boundary shifted by the cached key count.
				hide = (c > r + off);
			end else if (c != r && int'(req.ancestor_row) < r) begin
				// Draft row off the diagonal copies its parent's bit.
				hide = s.neg_inf_map[int'(req.ancestor_row) * ctam_pkg::DEF_MAX_COLS + c];
			end
		end
		res.value_bits = hide ? ctam_pkg::NEG_INF_BITS : req.score_bits;
		res.masked     = (res.value_bits == ctam_pkg::NEG_INF_BITS);
		res.row_end    = (c + 1 == cols);
		s.neg_inf_map[r * ctam_pkg::DEF_MAX_COLS + c] = res.masked;
		if (res.row_end) begin
			s.col_pos = 0;
			s.row_pos = (r + 1 >= rows) ? 0 : r + 1;
		end else begin
			s.col_pos = c + 1;
			s.row_pos = r;
		end
		return res;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			errors++;
		end
	endtask

	// Driver: presents requests and toggles the receiver's readiness.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			out_ready <= 1'b0;
		end else begin
			if (!in_valid || in_took) begin
				if (score_feed.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					in_data  <= score_feed.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Monitor: predicts on every accepted request and checks every result.
	always @(posedge clk) begin : monitor
		ctam_pkg::out_item_t want;
		if (!arst_n) begin
			in_took = 1'b0;
		end else begin
			in_took = in_valid && in_ready;
			if (cfg_valid && cfg_ready) apply_reg(live_st, cfg_index, cfg_data);
			if (in_took) expected_results.push_back(mask_step(live_st, in_data));
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result with nothing expected, actual %h", $time, out_data);
					errors++;
				end else begin
					want = expected_results.pop_front();
					check_field("value_bits", want.value_bits, out_data.value_bits);
					check_field("masked", 32'(want.masked), 32'(out_data.masked));
					check_field("row_end", 32'(want.row_end), 32'(out_data.row_end));
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic push_score(input logic [31:0] sc, input logic [5:0] anc);
		ctam_pkg::in_item_t req;
		req.score_bits   = sc;
		req.ancestor_row = anc;
		void'(mask_step(plan_st, req));
		score_feed.push_back(req);
	endtask

	// Waits until every request has gone and every result has come back.
	task automatic settle();
		while (score_feed.size() != 0 || in_valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	task automatic write_reg(input logic [ctam_pkg::CFG_IDX_W-1:0] idx,
		input logic [ctam_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		apply_reg(plan_st, idx, val);
	endtask

	// Picks a register setting, mostly small sizes with the extremes mixed in.
	task automatic random_setup();
		logic [6:0] rc;
		logic [6:0] len;
		logic [6:0] ctx;
		logic [6:0] off;
		case ($urandom_range(0, 7))
			0: rc = 7'd0;
			1: rc = 7'd1;
			2: rc = 7'd64;
			3: rc = 7'd127;
			default: rc = 7'($urandom_range(2, 8));
		endcase
		case ($urandom_range(0, 9))
			0: len = 7'd0;
			1: len = 7'd64;
			2: len = 7'd127;
			3: len = 7'($urandom_range(1, 127));
			default: len = 7'($urandom_range(1, 8));
		endcase
		case ($urandom_range(0, 7))
			0: ctx = 7'd0;
			1: ctx = 7'd64;
			2: ctx = 7'd127;
			3: ctx = 7'($urandom_range(0, 127));
			default: ctx = 7'($urandom_range(0, eff_count(rc, ctam_pkg::DEF_MAX_ROWS)));
		endcase
		case ($urandom_range(0, 5))
			0: off = 7'h40;
			1: off = 7'h3F;
			2: off = 7'($urandom_range(0, 127));
			default: off = 7'($urandom_range(0, 6) - 3);
		endcase
		write_reg(ctam_pkg::REG_ROW_COUNT, rc);
		write_reg(ctam_pkg::REG_ROW_LENGTH, len);
		write_reg(ctam_pkg::REG_CONTEXT_ROWS, ctx);
		write_reg(ctam_pkg::REG_COLUMN_OFFSET, off);
		if ($urandom_range(0, 5) == 0)
			write_reg(8'($urandom_range(4, 255)), 7'($urandom_range(0, 127)));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Well-formed rows keep one earlier parent; a few requests carry noise.
	task automatic queue_phase(input int n);
		logic [5:0]  parent;
		logic [5:0]  anc;
		logic [31:0] sc;
		int          row;
		parent = '0;
		for (int k = 0; k < n; k++) begin
			row = plan_st.row_pos;
			if (k == 0 || plan_st.col_pos == 0) begin
				if (row >= int'(plan_st.ctx_reg) && row > 0 && $urandom_range(0, 9) < 8)
					parent = 6'($urandom_range(0, row - 1));
				else
					parent = 6'($urandom_range(0, 63));
			end
			anc = ($urandom_range(0, 19) == 0) ? 6'($urandom_range(0, 63)) : parent;
			case ($urandom_range(0, 15))
				0: sc = ctam_pkg::NEG_INF_BITS;
				1: sc = 32'h0000_0000;
				2: sc = 32'hFFFF_FFFF;
				3: sc = 32'h7F80_0000;
				default: sc = $urandom;
			endcase
			push_score(sc, anc);
		end
	endtask

	task automatic run_regime(input int send_pct, input int recv_pct, input int quota);
		int sent;
		int n;
		sent = 0;
		while (sent < quota) begin
			settle();
			send_idle_pct = send_pct;
			recv_idle_pct = recv_pct;
			random_setup();
			n = $urandom_range(20, 120);
			queue_phase(n);
			sent += n;
		end
	endtask

	// Stimulus sequence.
	initial begin
		plan_st = fresh_state();
		live_st = fresh_state();
		send_idle_pct = 6;
		recv_idle_pct = 76;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset setting: a single row, so every score passes, negative infinity too.
		push_score(32'h0000_0000, 6'd0);
		push_score(32'hFFFF_FFFF, 6'd63);
		push_score(ctam_pkg::NEG_INF_BITS, 6'd0);
		settle();

		// Four by four head with one context row.
		write_reg(ctam_pkg::REG_ROW_COUNT, 7'd4);
		write_reg(ctam_pkg::REG_ROW_LENGTH, 7'd4);
		write_reg(ctam_pkg::REG_CONTEXT_ROWS, 7'd1);
		write_reg(ctam_pkg::REG_COLUMN_OFFSET, 7'd0);
		@(negedge clk);
		cfg_valid <= 1'b0;
		// Context row: only the first column survives the causal rule.
		for (int c = 0; c < 4; c++) push_score($urandom, 6'd63);
		// Draft rows: copy from the context row, then from a draft row.
		for (int c = 0; c < 4; c++) push_score($urandom, 6'd0);
		for (int c = 0; c < 4; c++) push_score($urandom, 6'd1);
		// Parents that are not earlier rows, then the diagonal: everything passes.
		push_score($urandom, 6'd3);
		push_score($urandom, 6'd3);
		push_score($urandom, 6'd5);
		push_score(ctam_pkg::NEG_INF_BITS, 6'd2);
		settle();

		// Zero rows clamp to one; a write to an unused index only restarts.
		write_reg(ctam_pkg::REG_ROW_COUNT, 7'd0);
		write_reg(8'hFF, 7'h7F);
		@(negedge clk);
		cfg_valid <= 1'b0;
		push_score(32'h7F80_0000, 6'd0);
		push_score(32'h0000_0001, 6'd0);

		run_regime(6, 76, 510);
		run_regime(76, 6, 510);
		run_regime(0, 0, 510);

		while (score_feed.size() != 0 || in_valid) @(negedge clk);
		while (expected_results.size() != 0) @(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
